/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by magnetometer_iron_correction_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* design/mic_pkg.sv */
// ----------------------------------------------------------------------------
// mic_pkg
// Types, widths and register codes for the magnetometer iron correction core.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int unsigned AXES                 = 3;
  localparam int unsigned SAMPLE_W             = 16;
  localparam int unsigned DIFF_W               = SAMPLE_W + 1;
  localparam int unsigned COEF_W               = 20;
  localparam int unsigned PROD_W               = DIFF_W + COEF_W;
  localparam int unsigned SUM_W                = PROD_W + 2;
  localparam int unsigned OFFSET_W             = AXES * SAMPLE_W;
  localparam int unsigned ROW_W                = AXES * COEF_W;
  localparam int unsigned CFG_DATA_W           = ROW_W;
  localparam int unsigned CFG_INDEX_W          = 2;
  localparam int unsigned COEF_FRAC_BITS_DEFAULT = 16;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_X  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_Y  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_Z  = 2'd3;

  typedef logic [DIFF_W-1:0] diff_t;
  typedef diff_t [AXES-1:0]  diff_vec_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef struct packed {
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_corrected;
    logic signed [SAMPLE_W-1:0] y_corrected;
    logic signed [SAMPLE_W-1:0] z_corrected;
    logic                       saturated;
  } result_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                clip;
  } lane_out_t;

  typedef lane_out_t [AXES-1:0] lane_vec_t;

endpackage

/* design/mic_lane.sv */
// ----------------------------------------------------------------------------
// mic_lane
// One matrix row: three products, registered sum, truncate toward zero and
// saturate to 16 bits.
// ----------------------------------------------------------------------------
module mic_lane #(
  parameter int unsigned COEF_FRAC_BITS = mic_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  mic_pkg::diff_vec_t  diff,
  input  mic_pkg::row_t       row,
  output mic_pkg::lane_out_t  lane_out
);

  localparam int unsigned PW = mic_pkg::PROD_W;
  localparam int unsigned SW = mic_pkg::SUM_W;
  localparam int unsigned CW = mic_pkg::COEF_W;

  localparam logic signed [SW-1:0] BIAS    = (SW'(1) << COEF_FRAC_BITS) - SW'(1);
  localparam logic signed [SW-1:0] SAT_MAX = SW'(mic_pkg::OUT_MAX);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(mic_pkg::OUT_MIN);

  logic signed [PW-1:0] diff_ext [mic_pkg::AXES];
  logic signed [PW-1:0] coef_ext [mic_pkg::AXES];
  logic signed [PW-1:0] prod     [mic_pkg::AXES];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_adj;
  logic signed [SW-1:0] quot;

  always_comb begin
    for (int c = 0; c < mic_pkg::AXES; c++) begin
      diff_ext[c] = PW'($signed(diff[c]));
      coef_ext[c] = PW'($signed(row[c*CW +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < mic_pkg::AXES; c++) begin
      prod[c] <= diff_ext[c] * coef_ext[c];
    end
    sum <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
  end

  // negative sums get a bias so the arithmetic shift rounds toward zero
  assign sum_adj = sum[SW-1] ? (sum + BIAS) : sum;
  assign quot    = sum_adj >>> COEF_FRAC_BITS;

  always_comb begin
    if (quot > SAT_MAX) begin
      lane_out.value = SAT_MAX[mic_pkg::SAMPLE_W-1:0];
      lane_out.clip  = 1'b1;
    end else if (quot < SAT_MIN) begin
      lane_out.value = SAT_MIN[mic_pkg::SAMPLE_W-1:0];
      lane_out.clip  = 1'b1;
    end else begin
      lane_out.value = quot[mic_pkg::SAMPLE_W-1:0];
      lane_out.clip  = 1'b0;
    end
  end

endmodule

/* design/mic_merge.sv */
// ----------------------------------------------------------------------------
// mic_merge
// Collects the three lane results, folds the clip flags, drives the output.
// ----------------------------------------------------------------------------
module mic_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                lanes_valid,
  input  mic_pkg::lane_vec_t  lanes,
  output logic                result_valid,
  output mic_pkg::result_t    result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= lanes_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.x_corrected <= $signed(lanes[0].value);
    result.y_corrected <= $signed(lanes[1].value);
    result.z_corrected <= $signed(lanes[2].value);
    result.saturated   <= lanes[0].clip | lanes[1].clip | lanes[2].clip;
  end

endmodule

/* design/magnetometer_iron_correction_core.sv */
// ----------------------------------------------------------------------------
// magnetometer_iron_correction_core
// Hard-iron offset removal and 3x3 soft-iron matrix correction of one
// three-axis magnetometer read per beat.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  ---------------------------------
//  sample    start / busy               sample (six raw bytes)
//  result    result_valid (strobe)      result (x/y/z corrected, saturated)
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  A sample beat is taken on any edge with start high and busy low; a new
//  beat may come every cycle. Pipeline registers, in order: offset subtract,
//  products, row sum, then truncate/saturate into the output register.
//  busy and cfg_ready only reflect reset (rst): no clearing pass is needed.
//  The result strobe is high for one cycle; there is no output stall.
//  Config writes are expected only while no sample is in flight.
//
module magnetometer_iron_correction_core #(
  parameter int unsigned COEF_FRAC_BITS = mic_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mic_pkg::sample_t                    sample,
  output logic                                result_valid,
  output mic_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mic_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mic_pkg::CFG_DATA_W-1:0]      cfg_data
);

  `include "assert_macros.svh"

  localparam int unsigned CW = mic_pkg::COEF_W;
  localparam int unsigned SW16 = mic_pkg::SAMPLE_W;
  localparam int unsigned DW = mic_pkg::DIFF_W;

  // unity coefficient placed in each column of the identity matrix
  localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;
  localparam mic_pkg::row_t ROW_X_RST = mic_pkg::ROW_W'(COEF_ONE);
  localparam mic_pkg::row_t ROW_Y_RST = mic_pkg::ROW_W'(COEF_ONE) << CW;
  localparam mic_pkg::row_t ROW_Z_RST = mic_pkg::ROW_W'(COEF_ONE) << (2 * CW);

  logic [mic_pkg::OFFSET_W-1:0] offset;
  mic_pkg::row_t                row [mic_pkg::AXES];

  logic                 accept;
  logic [SW16-1:0]      raw [mic_pkg::AXES];
  mic_pkg::diff_vec_t   diff_next;
  mic_pkg::diff_vec_t   diff;
  logic                 diff_valid;
  logic                 prod_valid;
  logic                 sum_valid;
  mic_pkg::lane_vec_t   lanes;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      row[0] <= ROW_X_RST;
      row[1] <= ROW_Y_RST;
      row[2] <= ROW_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mic_pkg::REG_OFFSET: offset <= cfg_data[mic_pkg::OFFSET_W-1:0];
        mic_pkg::REG_ROW_X:  row[0] <= cfg_data;
        mic_pkg::REG_ROW_Y:  row[1] <= cfg_data;
        mic_pkg::REG_ROW_Z:  row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: assemble and remove hard iron ----------------
  assign raw[0] = {sample.x_high_byte, sample.x_low_byte};
  assign raw[1] = {sample.y_high_byte, sample.y_low_byte};
  assign raw[2] = {sample.z_high_byte, sample.z_low_byte};

  // 17-bit difference, never wraps
  always_comb begin
    for (int a = 0; a < mic_pkg::AXES; a++) begin
      diff_next[a] = DW'($signed(raw[a])) - DW'($signed(offset[a*SW16 +: SW16]));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff <= diff_next;
    end
  end

  // valid tracking for the lane pipeline (products, then sum)
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      diff_valid <= accept;
      prod_valid <= diff_valid;
      sum_valid  <= prod_valid;
    end
  end

  // ---------------- stages 2-3: one lane per matrix row ----------------
  for (genvar k = 0; k < mic_pkg::AXES; k++) begin : g_lane
    mic_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .diff     (diff),
      .row      (row[k]),
      .lane_out (lanes[k])
    );
  end

  // ---------------- stage 4: merge and output register ----------------
  mic_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .lanes_valid  (sum_valid),
    .lanes        (lanes),
    .result_valid (result_valid),
    .result       (result)
  );

  // ---------------- checks ----------------
  `AST_PROP(a_latency, clk, rst, accept |-> ##4 result_valid,
            "accepted sample produced no result after four cycles")

  `AST_PROP(a_no_phantom, clk, rst, !accept |-> ##4 !result_valid,
            "result strobe without a matching sample")

  `AST_PROP(a_sat_flag, clk, rst,
            (result_valid && result.saturated) |->
              (result.x_corrected == 16'sh7fff || result.x_corrected == 16'sh8000 ||
               result.y_corrected == 16'sh7fff || result.y_corrected == 16'sh8000 ||
               result.z_corrected == 16'sh7fff || result.z_corrected == 16'sh8000),
            "saturated flag set but no axis at a limit")

endmodule
